// ===== rtl/slts_pkg.sv =====
// Shared types, constants and byte classification for the source lexer token splitter.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package slts_pkg;

  localparam int unsigned LINE_BITS    = 20;
  localparam int unsigned COLUMN_BITS  = 16;
  localparam int unsigned LENGTH_BITS  = 16;
  localparam int unsigned COL_CNT_BITS = $clog2(COLUMN_BITS);

  // Bytes the lexer looks for
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  // Configuration register indexes
  localparam logic CFG_TAB_SIZE  = 1'b0;
  localparam logic CFG_TAB_FIXED = 1'b1;

  typedef enum logic [3:0] {
    CLS_NONE          = 4'd0,
    CLS_NUMBER        = 4'd1,
    CLS_NAME          = 4'd2,
    CLS_CHAR          = 4'd3,
    CLS_STRING        = 4'd4,
    CLS_LPAREN        = 4'd5,
    CLS_RPAREN        = 4'd6,
    CLS_LBRACK        = 4'd7,
    CLS_RBRACK        = 4'd8,
    CLS_LBRACE        = 4'd9,
    CLS_RBRACE        = 4'd10,
    CLS_OPERATOR      = 4'd11,
    CLS_LINE_COMMENT  = 4'd12,
    CLS_BLOCK_COMMENT = 4'd13,
    CLS_INVALID       = 4'd14
  } cls_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_UNCLOSED = 3'd2,
    ST_CLEAN    = 3'd3,
    ST_STOPPED  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       at_end;
  } in_beat_t;

  typedef struct packed {
    logic                   byte_kept;
    logic                   byte_starts;
    logic                   token_done;
    logic [3:0]             done_class;
    logic [LINE_BITS-1:0]   done_line;
    logic [COLUMN_BITS-1:0] done_column;
    logic [LENGTH_BITS-1:0] done_length;
    logic [2:0]             status;
  } out_beat_t;

  // Classified byte with its position, front to back
  typedef struct packed {
    logic [7:0]             ch;
    logic                   at_end;
    cls_e                   first_cls;
    logic                   word_char;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
  } mid_entry_t;

  function automatic cls_e classify(input logic [7:0] c);
    cls_e r;
    case (c) inside
      CH_SPACE, CH_TAB, CH_NL, CH_CR, CH_VT, CH_FF: r = CLS_NONE;
      [8'h30:8'h39]:                                r = CLS_NUMBER;
      [8'h41:8'h5A], [8'h61:8'h7A], CH_USCORE:      r = CLS_NAME;
      CH_QUOTE:                                     r = CLS_CHAR;
      CH_DQUOTE:                                    r = CLS_STRING;
      CH_LPAREN:                                    r = CLS_LPAREN;
      CH_RPAREN:                                    r = CLS_RPAREN;
      CH_LBRACK:                                    r = CLS_LBRACK;
      CH_RBRACK:                                    r = CLS_RBRACK;
      CH_LBRACE:                                    r = CLS_LBRACE;
      CH_RBRACE:                                    r = CLS_RBRACE;
      [8'h00:8'h7F]:                                r = CLS_OPERATOR;
      default:                                      r = CLS_INVALID;
    endcase
    return r;
  endfunction

  // Letter, underscore or digit
  function automatic logic is_word(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_USCORE});
  endfunction

endpackage

// ===== rtl/slts_front.sv =====
// Front end: input beat acceptance, line/column/tab tracking, byte classification.
// Holds the tab registers and a bit-serial remainder unit. Uses slts_pkg.
module slts_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  slts_pkg::in_beat_t    in_beat_i,
  output logic                  full_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [7:0]            cfg_data_i,
  output logic                  mid_push_o,
  output slts_pkg::mid_entry_t  mid_entry_o,
  input  logic                  mid_full_i
);

  localparam int unsigned CB = slts_pkg::COLUMN_BITS;
  localparam int unsigned LB = slts_pkg::LINE_BITS;
  localparam int unsigned NB = slts_pkg::COL_CNT_BITS;

  logic [7:0]    tab_size_q, tab_size_d;
  logic          tab_fixed_q, tab_fixed_d;
  logic [LB-1:0] line_q, line_d;
  logic [CB-1:0] col_q, col_d;
  logic [7:0]    phase_q, phase_d;

  // remainder unit: column mod tab_size after a tab_size write
  logic          busy_q, busy_d;
  logic [NB-1:0] cnt_q, cnt_d;
  logic [7:0]    rem_q, rem_d;
  logic [CB-1:0] sh_q, sh_d;
  logic [8:0]    rem_try;
  logic [8:0]    rem_sub;
  logic [7:0]    rem_next;

  logic          accept;
  logic [7:0]    c;
  logic [7:0]    tab_add;
  logic [CB:0]   col_inc;
  logic [CB:0]   col_tab;
  logic [8:0]    phase_inc;

  assign full_o = mid_full_i || busy_q;
  assign accept = push_i && !full_o;
  assign c      = in_beat_i.at_end ? slts_pkg::CH_NL : in_beat_i.byte_in;

  assign tab_add   = tab_fixed_q ? tab_size_q : (tab_size_q - phase_q);
  assign col_inc   = {1'b0, col_q} + (CB+1)'(1);
  assign col_tab   = {1'b0, col_q} + (CB+1)'(tab_add);
  assign phase_inc = {1'b0, phase_q} + 9'd1;

  assign rem_try  = {rem_q, sh_q[CB-1]};
  assign rem_sub  = rem_try - {1'b0, tab_size_q};
  assign rem_next = (rem_try >= {1'b0, tab_size_q}) ? rem_sub[7:0] : rem_try[7:0];

  always_comb begin
    tab_size_d  = tab_size_q;
    tab_fixed_d = tab_fixed_q;
    line_d      = line_q;
    col_d       = col_q;
    phase_d     = phase_q;
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    sh_d        = sh_q;

    if (accept) begin
      if (c == slts_pkg::CH_NL) begin
        col_d   = '0;
        phase_d = '0;
        if (line_q != {LB{1'b1}}) line_d = line_q + LB'(1);
      end else if (c == slts_pkg::CH_TAB) begin
        if (tab_size_q != 8'd0) begin
          col_d = col_tab[CB] ? {CB{1'b1}} : col_tab[CB-1:0];
          if (!tab_fixed_q) phase_d = '0;
        end
      end else begin
        col_d   = col_inc[CB] ? {CB{1'b1}} : col_inc[CB-1:0];
        phase_d = (phase_inc == {1'b0, tab_size_q}) ? 8'd0 : phase_inc[7:0];
      end
    end

    if (busy_q) begin
      rem_d = rem_next;
      sh_d  = {sh_q[CB-2:0], 1'b0};
      cnt_d = cnt_q + NB'(1);
      if (cnt_q == NB'(CB - 1)) begin
        busy_d  = 1'b0;
        phase_d = rem_next;
      end
    end

    if (cfg_we_i) begin
      if (cfg_idx_i == slts_pkg::CFG_TAB_SIZE) begin
        tab_size_d = cfg_data_i;
        rem_d      = '0;
        sh_d       = col_q;
        cnt_d      = '0;
        busy_d     = (cfg_data_i != 8'd0);
        phase_d    = '0;
      end else begin
        tab_fixed_d = cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_size_q  <= 8'd4;
      tab_fixed_q <= 1'b0;
      line_q      <= LB'(1);
      col_q       <= '0;
      phase_q     <= '0;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      tab_size_q  <= tab_size_d;
      tab_fixed_q <= tab_fixed_d;
      line_q      <= line_d;
      col_q       <= col_d;
      phase_q     <= phase_d;
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign mid_push_o            = accept;
  assign mid_entry_o.ch        = c;
  assign mid_entry_o.at_end    = in_beat_i.at_end;
  assign mid_entry_o.first_cls = slts_pkg::classify(c);
  assign mid_entry_o.word_char = slts_pkg::is_word(c);
  assign mid_entry_o.line      = line_d;
  assign mid_entry_o.column    = col_d;

endmodule

// ===== rtl/slts_mid_fifo.sv =====
// Two-entry queue of classified bytes between front and back end.
// Uses slts_pkg::mid_entry_t.
module slts_mid_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  slts_pkg::mid_entry_t  entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output slts_pkg::mid_entry_t  head_o
);

  slts_pkg::mid_entry_t ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = ent_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wptr_q] <= entry_i;
  end

endmodule

// ===== rtl/slts_back.sv =====
// Back end: open-token tracking, close/keep/start decisions and the result queue.
// Consumes slts_mid_fifo entries; uses slts_pkg.
module slts_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  mid_empty_i,
  input  slts_pkg::mid_entry_t  mid_head_i,
  output logic                  mid_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output slts_pkg::out_beat_t   out_beat_o
);

  localparam int unsigned CB = slts_pkg::COLUMN_BITS;
  localparam int unsigned LB = slts_pkg::LINE_BITS;
  localparam int unsigned NB = slts_pkg::LENGTH_BITS;

  slts_pkg::cls_e open_cls_q, open_cls_d, cls_ext;
  logic [7:0]     last_q, last_d, prev_q, prev_d;
  logic [NB-1:0]  len_q, len_d;
  logic [LB-1:0]  sline_q, sline_d;
  logic [CB-1:0]  scol_q, scol_d;
  logic           stopped_q, stopped_d;

  logic                ext;
  logic [7:0]          quote;
  logic [NB-1:0]       cut;
  logic [NB-1:0]       trim_len;
  slts_pkg::out_beat_t res;
  slts_pkg::mid_entry_t e;

  // result queue
  slts_pkg::out_beat_t oq_q [2];
  logic       owptr_q, orptr_q;
  logic [1:0] ocnt_q, ocnt_d;
  logic       go, opop;

  assign e         = mid_head_i;
  assign go        = !mid_empty_i && ((ocnt_q != 2'd2) || pop_i);
  assign mid_pop_o = go;
  assign opop      = pop_i && (ocnt_q != 2'd0);
  assign empty_o   = (ocnt_q == 2'd0);
  assign out_beat_o = oq_q[orptr_q];

  assign quote = (open_cls_q == slts_pkg::CLS_CHAR) ? slts_pkg::CH_QUOTE : slts_pkg::CH_DQUOTE;
  assign cut   = (open_cls_q == slts_pkg::CLS_LINE_COMMENT)  ? NB'(3) :
                 (open_cls_q == slts_pkg::CLS_BLOCK_COMMENT) ? NB'(4) : NB'(0);
  assign trim_len = (len_q == {NB{1'b1}}) ? {NB{1'b1}} :
                    (len_q > cut) ? (len_q - cut) : NB'(0);

  always_comb begin
    ext       = 1'b0;
    cls_ext   = open_cls_q;
    res       = '0;
    open_cls_d = open_cls_q;
    last_d    = last_q;
    prev_d    = prev_q;
    len_d     = len_q;
    sline_d   = sline_q;
    scol_d    = scol_q;
    stopped_d = stopped_q;

    if (stopped_q) begin
      res.status = slts_pkg::ST_STOPPED;
    end else begin
      case (open_cls_q)
        slts_pkg::CLS_LINE_COMMENT: begin
          ext = (last_q != slts_pkg::CH_NL);
        end
        slts_pkg::CLS_BLOCK_COMMENT: begin
          ext = (len_q < NB'(2)) ||
                !((prev_q == slts_pkg::CH_STAR) && (last_q == slts_pkg::CH_SLASH));
        end
        slts_pkg::CLS_CHAR, slts_pkg::CLS_STRING: begin
          // the opening quote alone never closes; an escaped quote neither
          ext = (len_q <= NB'(1)) || (prev_q == slts_pkg::CH_BSLASH) || (last_q != quote);
        end
        slts_pkg::CLS_OPERATOR: begin
          if (last_q == slts_pkg::CH_SLASH && e.ch == slts_pkg::CH_SLASH) begin
            ext     = 1'b1;
            cls_ext = slts_pkg::CLS_LINE_COMMENT;
          end else if (last_q == slts_pkg::CH_SLASH && e.ch == slts_pkg::CH_STAR) begin
            ext     = 1'b1;
            cls_ext = slts_pkg::CLS_BLOCK_COMMENT;
          end
        end
        slts_pkg::CLS_NUMBER: begin
          ext = e.word_char || (e.ch == slts_pkg::CH_DASH) || (e.ch == slts_pkg::CH_DOT);
        end
        slts_pkg::CLS_NAME: begin
          ext = e.word_char;
        end
        default: begin
          ext = 1'b0;
        end
      endcase

      if (open_cls_q != slts_pkg::CLS_NONE) begin
        if (ext) begin
          open_cls_d    = cls_ext;
          prev_d        = last_q;
          last_d        = e.ch;
          if (len_q != {NB{1'b1}}) len_d = len_q + NB'(1);
          res.byte_kept = 1'b1;
        end else begin
          res.token_done  = 1'b1;
          res.done_class  = open_cls_q;
          res.done_line   = sline_q;
          res.done_column = scol_q;
          res.done_length = trim_len;
          open_cls_d      = slts_pkg::CLS_NONE;
          len_d           = '0;
          last_d          = '0;
          prev_d          = '0;
        end
      end

      if (e.at_end) begin
        res.status = (open_cls_d != slts_pkg::CLS_NONE) ? slts_pkg::ST_UNCLOSED
                                                        : slts_pkg::ST_CLEAN;
        stopped_d  = 1'b1;
      end else if (open_cls_d == slts_pkg::CLS_NONE) begin
        if (e.first_cls == slts_pkg::CLS_INVALID) begin
          res.status = slts_pkg::ST_INVALID;
          stopped_d  = 1'b1;
        end else if (e.first_cls != slts_pkg::CLS_NONE) begin
          open_cls_d      = e.first_cls;
          sline_d         = e.line;
          scol_d          = e.column;
          len_d           = NB'(1);
          last_d          = e.ch;
          prev_d          = '0;
          res.byte_starts = 1'b1;
        end
      end
    end
  end

  always_comb begin
    ocnt_d = ocnt_q;
    if (go && !opop) ocnt_d = ocnt_q + 2'd1;
    if (!go && opop) ocnt_d = ocnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_cls_q <= slts_pkg::CLS_NONE;
      last_q     <= '0;
      prev_q     <= '0;
      len_q      <= '0;
      sline_q    <= '0;
      scol_q     <= '0;
      stopped_q  <= 1'b0;
      owptr_q    <= 1'b0;
      orptr_q    <= 1'b0;
      ocnt_q     <= 2'd0;
    end else begin
      ocnt_q <= ocnt_d;
      if (opop) orptr_q <= !orptr_q;
      if (go) begin
        owptr_q    <= !owptr_q;
        open_cls_q <= open_cls_d;
        last_q     <= last_d;
        prev_q     <= prev_d;
        len_q      <= len_d;
        sline_q    <= sline_d;
        scol_q     <= scol_d;
        stopped_q  <= stopped_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) oq_q[owptr_q] <= res;
  end

endmodule

// ===== rtl/source_lexer_token_splitter.sv =====
// Top level of the source lexer token splitter: front end, middle queue, back end.
// Depends on slts_pkg, slts_front, slts_mid_fifo and slts_back.
//
// Usage:
//   Input channel: one source byte per beat (in_beat_i.byte_in), or an end
//   marker (in_beat_i.at_end) that is lexed as a newline. A beat is taken at
//   a clock edge with push high and full low.
//   Result channel: exactly one result beat per input beat, in order. The
//   oldest result is on out_beat_o while empty is low; it is taken at a clock
//   edge with pop high and empty low.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 tab_size, 1 tab_fixed) at the edge. Write only while the block is idle.
// Timing:
//   A taken beat is registered in the middle queue and its result in the result
//   queue, which drives out_beat_o. Throughput is one byte per cycle while full is
//   low; the line/column update and the token decision each sit in their own stage.
//   A nonzero tab_size write runs a bit-serial remainder of the column, one bit
//   per cycle, to re-derive the tab phase; full stays high meanwhile.
// Reset: line 1, column 0, no token open, tab_size 4, tab_fixed 0, queues empty.
// Stall: with pop held low both two-deep queues fill, then full rises; no beat is lost.
// After the end marker or an invalid byte every further beat reports stopped.
module source_lexer_token_splitter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  slts_pkg::in_beat_t   in_beat_i,
  output logic                 empty,
  input  logic                 pop,
  output slts_pkg::out_beat_t  out_beat_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  // front -> middle queue
  logic                 mid_push;
  slts_pkg::mid_entry_t mid_entry;
  logic                 mid_full;
  // middle queue -> back
  logic                 mid_pop;
  logic                 mid_empty;
  slts_pkg::mid_entry_t mid_head;

  slts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_beat_i   (in_beat_i),
    .full_o      (full),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .mid_push_o  (mid_push),
    .mid_entry_o (mid_entry),
    .mid_full_i  (mid_full)
  );

  slts_mid_fifo u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .entry_i (mid_entry),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .head_o  (mid_head)
  );

  slts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_head_i  (mid_head),
    .mid_pop_o   (mid_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_beat_o  (out_beat_o)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for source_lexer_token_splitter: byte driver, result monitor and
// an in-bench lexer predictor. Depends on rtl/slts_pkg.sv and rtl/source_lexer_token_splitter.sv.
module tb;
  import slts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned COL_TOP     = (1 << COLUMN_BITS) - 1;

  // Clock, reset and block ports. Every input has a known value from time zero.
  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       push     = 1'b0;
  logic       full;
  in_beat_t   in_beat  = '0;
  logic       empty;
  logic       pop      = 1'b0;
  out_beat_t  out_beat;
  logic       cfg_we   = 1'b0;
  logic       cfg_idx  = CFG_TAB_SIZE;
  logic [7:0] cfg_data = '0;

  source_lexer_token_splitter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_beat_i  (in_beat),
    .empty      (empty),
    .pop        (pop),
    .out_beat_o (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial forever #1 clk_i = ~clk_i;

  // Source bytes waiting to be offered, and lexer results predicted for accepted bytes.
  in_beat_t  pending_bytes[$];
  out_beat_t predicted_results[$];

  // Pacing knobs, set by the stimulus process; the idle percentages only while the block is idle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles   = 0;

  int unsigned cycle_count   = 0;
  int unsigned bytes_queued  = 0;
  int unsigned bytes_sent    = 0;
  int unsigned beats_checked = 0;
  int unsigned tokens_closed = 0;
  int unsigned fail_count    = 0;

  string op_chars = "+-*/=<>!&|^%~?:;,.@#$\\";

  // ---------------------------------------------------------------------------
  // Lexer predictor: its own copy of the register values and lexer state.
  // ---------------------------------------------------------------------------
  logic [7:0]             tab_w;
  logic                   tab_fix;
  cls_e                   lx_cls;
  logic [15:0]            lx_tail;     // last two kept bytes, newest in the low byte
  logic [LENGTH_BITS-1:0] lx_len;
  logic [LINE_BITS-1:0]   lx_sline;
  logic [COLUMN_BITS-1:0] lx_scol;
  logic [LINE_BITS-1:0]   lx_line;
  logic [COLUMN_BITS-1:0] lx_col;
  logic                   lx_halted;

  initial begin
    tab_w     = 8'd4;
    tab_fix   = 1'b0;
    lx_cls    = CLS_NONE;
    lx_tail   = '0;
    lx_len    = '0;
    lx_sline  = '0;
    lx_scol   = '0;
    lx_line   = LINE_BITS'(1);
    lx_col    = '0;
    lx_halted = 1'b0;
  end

  function automatic logic alpha_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_USCORE;
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic cls_e first_class(input logic [7:0] c);
    cls_e r;
    if (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR || c == CH_VT || c == CH_FF)
      r = CLS_NONE;
    else if (digit_byte(c))
      r = CLS_NUMBER;
    else if (alpha_byte(c))
      r = CLS_NAME;
    else begin
      case (c)
        CH_QUOTE:  r = CLS_CHAR;
        CH_DQUOTE: r = CLS_STRING;
        CH_LPAREN: r = CLS_LPAREN;
        CH_RPAREN: r = CLS_RPAREN;
        CH_LBRACK: r = CLS_LBRACK;
        CH_RBRACK: r = CLS_RBRACK;
        CH_LBRACE: r = CLS_LBRACE;
        CH_RBRACE: r = CLS_RBRACE;
        default:   r = c[7] ? CLS_INVALID : CLS_OPERATOR;
      endcase
    end
    return r;
  endfunction

  // Advances the lexer by one accepted beat and returns the result it must produce.
  function automatic out_beat_t lex_step(input in_beat_t b);
    out_beat_t              r;
    logic [7:0]             c;
    logic [7:0]             last;
    logic [7:0]             prev;
    logic [7:0]             quote;
    logic                   ext;
    int unsigned            nc;
    logic [LENGTH_BITS-1:0] cut;
    cls_e                   sc;
    r = '0;
    if (lx_halted) begin
      r.status = ST_STOPPED;
      return r;
    end
    c = b.at_end ? CH_NL : b.byte_in;

    // position first: the reported column is the one after this byte
    if (c == CH_NL) begin
      lx_col = '0;
      if (lx_line != '1) lx_line = lx_line + 1'b1;
    end else if (c == CH_TAB) begin
      if (tab_w != 0) begin
        nc = tab_fix ? lx_col + tab_w : (lx_col / tab_w) * tab_w + tab_w;
        lx_col = COLUMN_BITS'((nc > COL_TOP) ? COL_TOP : nc);
      end
    end else if (lx_col != '1) begin
      lx_col = lx_col + 1'b1;
    end

    // offer the byte to the open token
    if (lx_cls != CLS_NONE) begin
      last = lx_tail[7:0];
      prev = lx_tail[15:8];
      ext  = 1'b0;
      case (lx_cls)
        CLS_LINE_COMMENT:  ext = (last != CH_NL);
        CLS_BLOCK_COMMENT: ext = (lx_len < 2) || !(prev == CH_STAR && last == CH_SLASH);
        CLS_CHAR, CLS_STRING: begin
          quote = (lx_cls == CLS_CHAR) ? CH_QUOTE : CH_DQUOTE;
          if (lx_len <= 1) prev = CH_BSLASH;  // opening quote alone never closes
          ext = (prev == CH_BSLASH) || (last != quote);
        end
        CLS_OPERATOR: begin
          if (last == CH_SLASH && (c == CH_SLASH || c == CH_STAR)) begin
            lx_cls = (c == CH_SLASH) ? CLS_LINE_COMMENT : CLS_BLOCK_COMMENT;
            ext    = 1'b1;
          end
        end
        CLS_NUMBER: ext = alpha_byte(c) || digit_byte(c) || c == CH_DASH || c == CH_DOT;
        CLS_NAME:   ext = alpha_byte(c) || digit_byte(c);
        default:    ext = 1'b0;
      endcase
      if (ext) begin
        lx_tail     = {lx_tail[7:0], c};
        if (lx_len != '1) lx_len = lx_len + 1'b1;
        r.byte_kept = 1'b1;
      end else begin
        r.token_done  = 1'b1;
        r.done_class  = lx_cls;
        r.done_line   = lx_sline;
        r.done_column = lx_scol;
        cut = (lx_cls == CLS_LINE_COMMENT)  ? LENGTH_BITS'(3) :
              (lx_cls == CLS_BLOCK_COMMENT) ? LENGTH_BITS'(4) : LENGTH_BITS'(0);
        if (lx_len == '1) r.done_length = lx_len;  // saturated: delimiters stay counted
        else              r.done_length = (lx_len > cut) ? lx_len - cut : '0;
        lx_cls  = CLS_NONE;
        lx_len  = '0;
        lx_tail = '0;
      end
    end

    if (b.at_end) begin
      r.status  = (lx_cls != CLS_NONE) ? ST_UNCLOSED : ST_CLEAN;
      lx_halted = 1'b1;
    end else if (lx_cls == CLS_NONE) begin
      sc = first_class(c);
      if (sc == CLS_INVALID) begin
        r.status  = ST_INVALID;
        lx_halted = 1'b1;
      end else if (sc != CLS_NONE) begin
        lx_cls        = sc;
        lx_sline      = lx_line;
        lx_scol       = lx_col;
        lx_len        = LENGTH_BITS'(1);
        lx_tail       = {8'h00, c};
        r.byte_starts = 1'b1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the head of pending_bytes; predicts on each accepted beat.
  // A stalled beat (push high, full high) is held as is.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver
    logic next_push;
    if (rst_ni) begin
      next_push = push;
      if (push && !full) begin
        predicted_results = {predicted_results, lex_step(in_beat)};
        void'(pending_bytes.pop_front());
        bytes_sent++;
        next_push = 1'b0;
      end
      if (!next_push && pending_bytes.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        next_push = 1'b1;
        in_beat  <= pending_bytes[0];
      end
      push <= next_push;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each popped beat against the oldest prediction, field by field.
  // hold_cycles forces a long run with pop low so the block backs up.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want_v, got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    out_beat_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        beats_checked++;
        if (predicted_results.size() == 0) begin
          $display("%0t: result beat %h with nothing expected", $time, out_beat);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("byte_kept",   32'(want.byte_kept),   32'(out_beat.byte_kept));
          check_field("byte_starts", 32'(want.byte_starts), 32'(out_beat.byte_starts));
          check_field("token_done",  32'(want.token_done),  32'(out_beat.token_done));
          check_field("done_class",  32'(want.done_class),  32'(out_beat.done_class));
          check_field("done_line",   32'(want.done_line),   32'(out_beat.done_line));
          check_field("done_column", 32'(want.done_column), 32'(out_beat.done_column));
          check_field("done_length", 32'(want.done_length), 32'(out_beat.done_length));
          check_field("status",      32'(want.status),      32'(out_beat.status));
          if (want.token_done) tokens_closed++;
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached, %0d beats still expected",
               $time, CYCLE_LIMIT, predicted_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] c);
    in_beat_t b;
    b.byte_in = c;
    b.at_end  = 1'b0;
    pending_bytes = {pending_bytes, b};
    bytes_queued++;
  endtask

  // End marker; byte_in is random since it is ignored
  task automatic add_end();
    in_beat_t b;
    b.byte_in = 8'($urandom_range(0, 255));
    b.at_end  = 1'b1;
    pending_bytes = {pending_bytes, b};
    bytes_queued++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned k;
    k = $urandom_range(0, 52);
    if (k < 26) return 8'(8'h61 + k);
    if (k < 52) return 8'(8'h41 + k - 26);
    return CH_USCORE;
  endfunction

  function automatic logic [7:0] rand_word();
    if ($urandom_range(0, 1)) return rand_letter();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 7))
      0:       return CH_TAB;
      1:       return CH_NL;
      2:       return CH_CR;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_SPACE;
    endcase
  endfunction

  // One token with random content, or a run of blanks, or noise.
  // Noise stays below 0x80 so the stream does not stop early.
  task automatic add_token();
    int unsigned n;
    logic [7:0]  p;
    n = $urandom_range(0, 6);
    case ($urandom_range(0, 11))
      0: begin                                   // number, with '-' and '.' inside
        add_byte(8'(8'h30 + $urandom_range(0, 9)));
        repeat (n) begin
          case ($urandom_range(0, 4))
            0:       add_byte(CH_DASH);
            1:       add_byte(CH_DOT);
            default: add_byte(rand_word());
          endcase
        end
      end
      1: begin                                   // name
        add_byte(rand_letter());
        repeat (n) add_byte(rand_word());
      end
      2: begin                                   // char literal, sometimes escaped
        add_byte(CH_QUOTE);
        if ($urandom_range(0, 2) == 0) begin
          add_byte(CH_BSLASH);
          add_byte(8'($urandom_range(32, 126)));
        end else if ($urandom_range(0, 5) != 0) begin
          add_byte(rand_letter());
        end
        add_byte(CH_QUOTE);
      end
      3: begin                                   // string with escapes
        add_byte(CH_DQUOTE);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            add_byte(CH_BSLASH);
            add_byte(CH_DQUOTE);
          end else begin
            add_byte(8'($urandom_range(32, 126)));
          end
        end
        add_byte(CH_DQUOTE);
      end
      4: begin                                   // brackets
        case ($urandom_range(0, 5))
          0: add_byte(CH_LPAREN);
          1: add_byte(CH_RPAREN);
          2: add_byte(CH_LBRACK);
          3: add_byte(CH_RBRACK);
          4: add_byte(CH_LBRACE);
          default: add_byte(CH_RBRACE);
        endcase
      end
      5: add_byte(op_chars[$urandom_range(0, op_chars.len() - 1)]);
      6: begin                                   // line comment
        add_text("//");
        repeat (n) add_byte(8'($urandom_range(32, 126)));
        add_byte(CH_NL);
      end
      7: begin                                   // block comment, stars and slashes inside
        add_text("/*");
        repeat (n) begin
          case ($urandom_range(0, 3))
            0:       add_byte(CH_STAR);
            1:       add_byte(CH_SLASH);
            default: add_byte(8'($urandom_range(32, 126)));
          endcase
        end
        add_text("*/");
      end
      8: repeat (n + 1) add_byte(rand_blank());
      9: repeat (n + 1) add_byte(CH_TAB);
      default: repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 127)));
    endcase
    // most tokens get a separator; the rest close on, or run into, the next token's first byte
    if ($urandom_range(0, 9) < 7) add_byte(rand_blank());
  endtask

  task automatic add_random(input int unsigned count);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < count) add_token();
  endtask

  // Idle = nothing queued, nothing offered, nothing outstanding; then cover the latency.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || push || predicted_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    if (idx == CFG_TAB_SIZE) tab_w = v;
    else                     tab_fix = v[0];
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]  mid_tab;
    string       end_kind;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Pass 1: narrowest tab stop, sender idles lightly, receiver heavily.
    write_reg(CFG_TAB_SIZE, 8'd1);
    write_reg(CFG_TAB_FIXED, 8'd0);
    send_idle_pct = 20;
    recv_idle_pct = 63;
    // Directed: name with '_', number with '.' and '-', tab, escaped quote char,
    // empty string, all six brackets, an operator closed by the next byte,
    // an empty line comment and the slash-star-slash block comment.
    add_text("_Z9 0.-a\t'\\''\"\"([{}])+//\n/*/ ");
    add_text("\"\"x");
    // Receiver stalls for a long stretch while the sender keeps offering.
    hold_cycles = 300;
    add_random(150);
    wait_idle();

    // Pass 2: fixed-width tabs of random size, pacing reversed.
    mid_tab = 8'($urandom_range(2, 64));
    write_reg(CFG_TAB_SIZE, mid_tab);
    write_reg(CFG_TAB_FIXED, 8'd1);
    send_idle_pct = 63;
    recv_idle_pct = 20;
    add_random(150);
    wait_idle();

    // Pass 3: widest tab stop, no idling; column saturation.
    write_reg(CFG_TAB_SIZE, 8'd255);
    write_reg(CFG_TAB_FIXED, 8'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (260) add_byte(CH_TAB);
    add_text("q1 ");                 // starts at the saturated column
    add_byte(CH_NL);
    add_random(90);

    // One way to stop, picked by the seed; the stopped beats after it carry
    // high bytes and a second end marker.
    case ($urandom_range(0, 2))
      0: begin
        end_kind = "invalid byte";
        add_byte(8'($urandom_range(128, 255)));
      end
      1: begin
        end_kind = "clean end";
        add_text("end");
        add_end();
      end
      default: begin
        end_kind = "unclosed line comment at end";
        add_text("// open");
        add_end();
      end
    endcase
    add_byte(8'h80);
    add_byte(8'hFF);
    add_end();
    repeat (4) add_byte(8'($urandom_range(0, 255)));
    wait_idle();

    // Registers stay writable once stopped; results must stay stopped.
    write_reg(CFG_TAB_FIXED, 8'd1);
    add_byte("a");
    add_byte(CH_TAB);
    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("tb: %0d bytes sent across tab widths 1, %0d and 255 under three pacings",
             bytes_sent, mid_tab);
    $display("tb: %0d result beats checked, %0d tokens closed, stream stopped by %s",
             beats_checked, tokens_closed, end_kind);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", fail_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== source_lexer_token_splitter.f =====
rtl/slts_pkg.sv
rtl/slts_front.sv
rtl/slts_mid_fifo.sv
rtl/slts_back.sv
rtl/source_lexer_token_splitter.sv
dv/tb.sv
